// ----- rtl/tcc_pkg.sv -----
// Package for the thermal code calibration converter.
// Holds request and response types, field widths, codes and the untrimmed tables.
// No dependencies.
package tcc_pkg;

  localparam int TRIM_REGS           = 7;
  localparam int TRIM_W              = 20;
  localparam int VALUE_W             = 9;
  localparam int RESULT_W            = 11;
  localparam int SPAN_W              = 10;
  localparam int PROD_W              = 20;
  localparam int PROD_MAG_W          = 18;
  localparam int DEN_W               = 9;
  localparam int DIV_STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES          = PROD_MAG_W / DIV_STEPS_PER_STAGE;
  localparam int TCC_LATENCY         = 5 + DIV_STAGES;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 24;
  localparam int RES_MIN             = -1024;
  localparam int RES_MAX             = 1023;

  localparam logic [CFG_IDX_W-1:0]  CFG_CAL_POINTS   = 3'd7;
  localparam logic [CFG_DATA_W-1:0] CAL_POINTS_RESET = 24'h325519;

  localparam logic OP_CODE_TO_TEMP = 1'b0;
  localparam logic OP_TEMP_TO_CODE = 1'b1;

  localparam logic [1:0] CAL_TABLE     = 2'd0;
  localparam logic [1:0] CAL_OFFSET    = 2'd1;
  localparam logic [1:0] CAL_TWO_POINT = 2'd2;
  localparam logic [1:0] CAL_DEFAULT   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SAT       = 2'd1;
  localparam logic [1:0] ST_DIV0      = 2'd2;
  localparam logic [1:0] ST_BAD_PROBE = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic [2:0]         probe;
    logic [VALUE_W-1:0] value;
  } tcc_req_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic [1:0]                 status;
  } tcc_rsp_t;

  typedef struct packed {
    logic                       bad_probe;
    logic                       interp;
    logic                       div0;
    logic                       q_neg;
    logic [VALUE_W-1:0]         base_out;
    logic signed [RESULT_W-1:0] simple;
  } tcc_side_t;

  function automatic logic [VALUE_W-1:0] untrimmed_e1(logic [2:0] probe);
    logic [VALUE_W-1:0] e;
    case (probe)
      3'd0:    e = 9'd287;
      3'd1:    e = 9'd286;
      3'd2:    e = 9'd287;
      3'd3:    e = 9'd287;
      3'd4:    e = 9'd286;
      3'd5:    e = 9'd286;
      3'd6:    e = 9'd286;
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic logic [VALUE_W-1:0] untrimmed_e2(logic [2:0] probe);
    logic [VALUE_W-1:0] e;
    case (probe)
      3'd0:    e = 9'd346;
      3'd1:    e = 9'd346;
      3'd2:    e = 9'd347;
      3'd3:    e = 9'd347;
      3'd4:    e = 9'd347;
      3'd5:    e = 9'd346;
      3'd6:    e = 9'd346;
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/tcc_divider.sv -----
// Pipelined restoring divider on magnitudes for the calibration converter.
// Retires DIV_STEPS_PER_STAGE quotient bits per stage and carries a sideband along.
// Depends on tcc_pkg.
module tcc_divider import tcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  logic [PROD_MAG_W-1:0] dividend,
  input  logic [DEN_W-1:0]      divisor,
  input  tcc_side_t             in_side,
  output logic                  out_vld,
  output logic [PROD_MAG_W-1:0] quotient,
  output tcc_side_t             out_side
);

  typedef struct packed {
    logic [DEN_W-1:0]      rem;
    logic [PROD_MAG_W-1:0] dvd;
    logic [PROD_MAG_W-1:0] quo;
    logic [DEN_W-1:0]      dsr;
    tcc_side_t             side;
  } div_state_t;

  function automatic div_state_t div_steps(div_state_t s);
    div_state_t     o;
    logic [DEN_W+1:0] trial;
    o = s;
    for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
      trial = {1'b0, o.rem, o.dvd[PROD_MAG_W-1]} - {2'b00, o.dsr};
      if (!trial[DEN_W+1]) begin
        o.rem = trial[DEN_W-1:0];
      end else begin
        o.rem = {o.rem[DEN_W-2:0], o.dvd[PROD_MAG_W-1]};
      end
      o.quo = {o.quo[PROD_MAG_W-2:0], ~trial[DEN_W+1]};
      o.dvd = {o.dvd[PROD_MAG_W-2:0], 1'b0};
    end
    return o;
  endfunction

  div_state_t            st_in;
  div_state_t            st_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_q;

  always_comb begin
    st_in.rem  = '0;
    st_in.dvd  = dividend;
    st_in.quo  = '0;
    st_in.dsr  = divisor;
    st_in.side = in_side;
  end

  always_ff @(posedge clk) begin
    st_q[0] <= div_steps(st_in);
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_q[k] <= div_steps(st_q[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STAGES-2:0], in_vld};
    end
  end

  assign out_vld  = vld_q[DIV_STAGES-1];
  assign quotient = st_q[DIV_STAGES-1].quo;
  assign out_side = st_q[DIV_STAGES-1].side;

endmodule

// ----- rtl/thermal_code_calibration_converter.sv -----
// Top level of the thermal code calibration converter: trim registers, operand
// stages, multiplier, divider and output stage. Depends on tcc_pkg, tcc_divider.
//
//   channel   signals                                  direction  handshake
//   request   start, busy, request                     in         start & !busy
//   response  strobe, response                         out        strobe, one cycle
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in        cfg_valid & cfg_ready
//
// One request per cycle; each request passes registers s1, s2 and s3, then the
// eighteen-bit divide split over six stages, then s4 and the response register.
// busy stays low and cfg_ready stays high: the pipeline never stalls.
// Reset clears all valid bits and loads the trim defaults; requests in flight are dropped.
module thermal_code_calibration_converter import tcc_pkg::*; #(
  parameter int NUM_PROBES = 7,
  parameter int CODE_BITS  = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  tcc_req_t              request,
  output logic                  strobe,
  output tcc_rsp_t              response,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TRIM_STORE = (NUM_PROBES < TRIM_REGS) ? NUM_PROBES : TRIM_REGS;
  localparam int USED_BITS  = (CODE_BITS < VALUE_W) ? CODE_BITS : VALUE_W;
  localparam logic [VALUE_W-1:0] VALUE_MASK =
    VALUE_W'((VALUE_W+1)'(1) << USED_BITS) - VALUE_W'(1);

  typedef struct packed {
    logic signed [SPAN_W-1:0] diff;
    logic signed [SPAN_W-1:0] num;
    logic signed [SPAN_W-1:0] den;
    tcc_side_t                side;
  } s1_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic [DEN_W-1:0]         den_mag;
    logic                     den_neg;
    tcc_side_t                side;
  } s2_t;

  typedef struct packed {
    logic [PROD_MAG_W-1:0] prod_mag;
    logic [DEN_W-1:0]      den_mag;
    tcc_side_t             side;
  } s3_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] r;
    tcc_side_t                side;
  } s4_t;

  logic [TRIM_W-1:0]     trim [TRIM_STORE];
  logic [CFG_DATA_W-1:0] cal_points;

  logic [TRIM_W-1:0]      w;
  logic [1:0]             trim_kind;
  logic                   probe_ok;
  logic [VALUE_W-1:0]     v;
  logic [VALUE_W-1:0]     e1;
  logic [VALUE_W-1:0]     e2;
  logic [7:0]             t1;
  logic [7:0]             t2;
  logic [7:0]             off;
  logic [VALUE_W-1:0]     base_in;
  logic signed [RESULT_W:0] simple_wide;
  s1_t                    s1_next;

  s1_t s1;
  s2_t s2;
  s3_t s3;
  s4_t s4;
  logic s1_vld;
  logic s2_vld;
  logic s3_vld;
  logic s4_vld;

  logic                  q_vld;
  logic [PROD_MAG_W-1:0] q_mag;
  tcc_side_t             q_side;
  tcc_side_t             s3_side_next;
  logic signed [PROD_MAG_W:0] q_signed;
  logic signed [PROD_W-1:0]   r_interp;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRIM_STORE; i++) begin
        trim[i] <= '0;
      end
      cal_points <= CAL_POINTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < TRIM_STORE; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          trim[i] <= cfg_data[TRIM_W-1:0];
        end
      end
      if (cfg_index == CFG_CAL_POINTS) begin
        cal_points <= cfg_data;
      end
    end
  end

  always_comb begin
    w = '0;
    for (int i = 0; i < TRIM_STORE; i++) begin
      if (request.probe == 3'(i)) begin
        w = trim[i];
      end
    end
    probe_ok = (32'(request.probe) < NUM_PROBES) && (32'(request.probe) < TRIM_REGS);
    trim_kind = w[19:18];
    e1 = (trim_kind == CAL_TABLE) ? untrimmed_e1(request.probe) : w[8:0];
    e2 = (trim_kind == CAL_TABLE) ? untrimmed_e2(request.probe) : w[17:9];
    t1  = cal_points[7:0];
    t2  = cal_points[15:8];
    off = cal_points[23:16];
    v   = request.value & VALUE_MASK;

    if (request.opcode == OP_CODE_TO_TEMP) begin
      s1_next.num        = $signed({2'b00, t2}) - $signed({2'b00, t1});
      s1_next.den        = $signed({1'b0, e2}) - $signed({1'b0, e1});
      base_in            = e1;
      s1_next.side.base_out = {1'b0, t1};
    end else begin
      s1_next.num        = $signed({1'b0, e2}) - $signed({1'b0, e1});
      s1_next.den        = $signed({2'b00, t2}) - $signed({2'b00, t1});
      base_in            = {1'b0, t1};
      s1_next.side.base_out = e1;
    end
    s1_next.diff = $signed({1'b0, v}) - $signed({1'b0, base_in});

    case (trim_kind)
      CAL_OFFSET: begin
        if (request.opcode == OP_CODE_TO_TEMP) begin
          simple_wide = $signed({3'b000, v}) - $signed({3'b000, e1}) + $signed({4'b0000, t1});
        end else begin
          simple_wide = $signed({3'b000, v}) + $signed({3'b000, e1}) - $signed({4'b0000, t1});
        end
      end
      default: begin
        if (request.opcode == OP_CODE_TO_TEMP) begin
          simple_wide = $signed({3'b000, v}) - $signed({4'b0000, off});
        end else begin
          simple_wide = $signed({3'b000, v}) + $signed({4'b0000, off});
        end
      end
    endcase

    s1_next.side.bad_probe = ~probe_ok;
    s1_next.side.interp    = (trim_kind == CAL_TABLE) || (trim_kind == CAL_TWO_POINT);
    s1_next.side.div0      = (s1_next.den == '0);
    s1_next.side.q_neg     = 1'b0;
    s1_next.side.simple    = simple_wide[RESULT_W-1:0];
  end

  always_comb begin
    s3_side_next       = s2.side;
    s3_side_next.q_neg = s2.prod[PROD_W-1] ^ s2.den_neg;
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;

    s2.prod    <= s1.diff * s1.num;
    s2.den_mag <= s1.den[SPAN_W-1] ? DEN_W'(-s1.den) : s1.den[DEN_W-1:0];
    s2.den_neg <= s1.den[SPAN_W-1];
    s2.side    <= s1.side;

    s3.prod_mag <= s2.prod[PROD_W-1] ? PROD_MAG_W'(-s2.prod) : s2.prod[PROD_MAG_W-1:0];
    s3.den_mag  <= s2.den_mag;
    s3.side     <= s3_side_next;
  end

  tcc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s3_vld),
    .dividend (s3.prod_mag),
    .divisor  (s3.den_mag),
    .in_side  (s3.side),
    .out_vld  (q_vld),
    .quotient (q_mag),
    .out_side (q_side)
  );

  always_comb begin
    q_signed = q_side.q_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    r_interp = PROD_W'($signed({q_signed[PROD_MAG_W], q_signed}))
             + $signed({{(PROD_W-VALUE_W){1'b0}}, q_side.base_out});
  end

  always_ff @(posedge clk) begin
    s4.r    <= q_side.interp ? r_interp : PROD_W'(q_side.simple);
    s4.side <= q_side;

    if (s4.side.bad_probe) begin
      response.result <= '0;
      response.status <= ST_BAD_PROBE;
    end else if (s4.side.interp && s4.side.div0) begin
      response.result <= '0;
      response.status <= ST_DIV0;
    end else if (s4.r < RES_MIN) begin
      response.result <= RESULT_W'(RES_MIN);
      response.status <= ST_SAT;
    end else if (s4.r > RES_MAX) begin
      response.result <= RESULT_W'(RES_MAX);
      response.status <= ST_SAT;
    end else begin
      response.result <= s4.r[RESULT_W-1:0];
      response.status <= ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      strobe <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= q_vld;
      strobe <= s4_vld;
    end
  end

endmodule

// ----- rtl/tcc_checker.sv -----
// Port-level checker for the thermal code calibration converter, with its bind.
// Depends on tcc_pkg and the top level's port list.
module tcc_checker import tcc_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input tcc_req_t request,
  input logic     strobe,
  input tcc_rsp_t response
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##TCC_LATENCY strobe)
    else $error("response missing after request");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, TCC_LATENCY))
    else $error("response without request");

  a_bad_probe: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.probe == 3'd7 |->
      ##TCC_LATENCY (strobe && response.status == ST_BAD_PROBE))
    else $error("probe seven not flagged");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    strobe && (response.status == ST_BAD_PROBE || response.status == ST_DIV0)
      |-> response.result == '0)
    else $error("error response with nonzero result");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    strobe && response.status == ST_SAT |->
      (response.result == RESULT_W'(RES_MIN) || response.result == RESULT_W'(RES_MAX)))
    else $error("saturated result not at a bound");

endmodule

bind thermal_code_calibration_converter tcc_checker u_checker (.*);
